/* rtl/core/tod_pkg.sv */
// Shared types, constants and tables for the tilt orientation detector.
package tod_pkg;

  // Field and register widths fixed by the interface.
  localparam int FIELD_W   = 16;
  localparam int ANGLE_W   = 16;
  localparam int CODE_W    = 3;
  localparam int CFG_W     = 15;
  localparam int CFG_IDX_W = 2;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 24;

  // Defaults for the top-level parameters.
  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int CORDIC_STEPS_DEF = 14;

  // Fixed-point constants.
  localparam int PRESCALE_SH = 8;       // vector prescale by 2^8
  localparam int ZW          = 29;      // Q.24 angle accumulator, signed
  localparam int ROUND_SH    = 11;      // Q.24 -> Q2.13
  localparam int RW          = ZW - ROUND_SH;
  localparam int ROUND_BIAS  = 1024;
  localparam int PI_Q13      = 25736;
  localparam int PI_Q24      = 52707179;
  localparam int ATAN_IDX_W  = 5;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_FLAT_EDGE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PORTRAIT_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PORTRAIT_HIGH = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_EDGE     = 2'd3;

  // Register reset values (Q2.13 radians).
  localparam logic [CFG_W-1:0] FLAT_EDGE_RST     = 15'd2048;
  localparam logic [CFG_W-1:0] PORTRAIT_LOW_RST  = 15'd10240;
  localparam logic [CFG_W-1:0] PORTRAIT_HIGH_RST = 15'd14336;
  localparam logic [CFG_W-1:0] LEFT_EDGE_RST     = 15'd22528;

  // Orientation codes.
  localparam logic [CODE_W-1:0] ORI_UNKNOWN    = 3'd0;
  localparam logic [CODE_W-1:0] ORI_PORTRAIT   = 3'd1;
  localparam logic [CODE_W-1:0] ORI_LAND_RIGHT = 3'd2;
  localparam logic [CODE_W-1:0] ORI_UPSIDE     = 3'd3;
  localparam logic [CODE_W-1:0] ORI_LAND_LEFT  = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ITER,
    ST_ROUND,
    ST_EMIT
  } tod_state_t;

  typedef struct packed {
    logic load;   // capture a new sample and prerotate
    logic iter;   // run one CORDIC micro-rotation
    logic round;  // round and clamp the accumulated angle
    logic emit;   // classify and fill the output register
  } dp_cmd_t;

  typedef struct packed {
    logic last_step;
  } dp_status_t;

  // Arctangent of 2^-i in Q.24, rounded to nearest.
  function automatic logic [23:0] atan_q24(input logic [ATAN_IDX_W-1:0] idx);
    logic [23:0] v;
    case (idx)
      5'd0:    v = 24'd13176795;
      5'd1:    v = 24'd7778716;
      5'd2:    v = 24'd4110060;
      5'd3:    v = 24'd2086331;
      5'd4:    v = 24'd1047214;
      5'd5:    v = 24'd524117;
      5'd6:    v = 24'd262123;
      5'd7:    v = 24'd131069;
      5'd8:    v = 24'd65536;
      5'd9:    v = 24'd32768;
      5'd10:   v = 24'd16384;
      5'd11:   v = 24'd8192;
      5'd12:   v = 24'd4096;
      5'd13:   v = 24'd2048;
      5'd14:   v = 24'd1024;
      5'd15:   v = 24'd512;
      5'd16:   v = 24'd256;
      5'd17:   v = 24'd128;
      5'd18:   v = 24'd64;
      5'd19:   v = 24'd32;
      default: v = 24'd0;
    endcase
    return v;
  endfunction

endpackage

/* rtl/core/tod_ctrl.sv */
// Sequencing state machine for the tilt orientation detector.
module tod_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  output logic                out_tvalid,
  input  logic                out_tready,
  input  tod_pkg::dp_status_t status,
  output tod_pkg::dp_cmd_t    cmd
);

  tod_pkg::tod_state_t state_r, state_nxt;
  logic                out_tvalid_r, out_tvalid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= tod_pkg::ST_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      tod_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = tod_pkg::ST_ITER;
        end
      end
      tod_pkg::ST_ITER: begin
        cmd.iter = 1'b1;
        if (status.last_step) begin
          state_nxt = tod_pkg::ST_ROUND;
        end
      end
      tod_pkg::ST_ROUND: begin
        cmd.round = 1'b1;
        state_nxt = tod_pkg::ST_EMIT;
      end
      tod_pkg::ST_EMIT: begin
        // wait for the output register to drain
        if (!out_tvalid_r || out_tready) begin
          cmd.emit  = 1'b1;
          state_nxt = tod_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = tod_pkg::ST_IDLE;
      end
    endcase
    if (cmd.emit) begin
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end else begin
      out_tvalid_nxt = out_tvalid_r;
    end
  end

  assign out_tvalid = out_tvalid_r;

endmodule

/* rtl/core/tod_dp.sv */
// CORDIC vectoring datapath, band classifier and register file.
module tod_dp #(
  parameter int SAMPLE_WIDTH = tod_pkg::SAMPLE_WIDTH_DEF,
  parameter int CORDIC_STEPS = tod_pkg::CORDIC_STEPS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  tod_pkg::dp_cmd_t                  cmd,
  output tod_pkg::dp_status_t               status,
  input  logic [tod_pkg::FIELD_W-1:0]       in_accel_x,
  input  logic [tod_pkg::FIELD_W-1:0]       in_accel_y,
  input  logic                              cfg_we,
  input  logic [tod_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tod_pkg::CFG_W-1:0]         cfg_data,
  output logic signed [tod_pkg::ANGLE_W-1:0] out_angle,
  output logic [tod_pkg::CODE_W-1:0]        out_code,
  output logic                              out_changed
);

  localparam int EW = (SAMPLE_WIDTH > tod_pkg::FIELD_W) ? SAMPLE_WIDTH : tod_pkg::FIELD_W;
  localparam int AW = SAMPLE_WIDTH + 11;
  localparam int CW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
  localparam int TW = tod_pkg::CFG_W + 2;

  // Sample extraction: low SAMPLE_WIDTH bits, sign extended.
  logic [EW-1:0]                 raw_x, raw_y;
  logic signed [SAMPLE_WIDTH-1:0] sx, sy;
  logic signed [AW-1:0]          sx_w, sy_w;

  assign raw_x = EW'(in_accel_x);
  assign raw_y = EW'(in_accel_y);
  assign sx    = raw_x[SAMPLE_WIDTH-1:0];
  assign sy    = raw_y[SAMPLE_WIDTH-1:0];
  assign sx_w  = AW'(sx) <<< tod_pkg::PRESCALE_SH;
  assign sy_w  = AW'(sy) <<< tod_pkg::PRESCALE_SH;

  logic signed [AW-1:0]         a_r, b_r;
  logic signed [tod_pkg::ZW-1:0] z_r;
  logic [CW-1:0]                cnt_r;
  logic                         zero_r;
  logic signed [tod_pkg::ANGLE_W-1:0] angle_r;

  logic [tod_pkg::CFG_W-1:0] flat_edge_r, portrait_low_r, portrait_high_r, left_edge_r;
  logic [tod_pkg::CODE_W-1:0] ori_r;
  logic [tod_pkg::CODE_W-1:0] out_code_r;
  logic signed [tod_pkg::ANGLE_W-1:0] out_angle_r;
  logic out_changed_r;

  // One micro-rotation.
  logic signed [AW-1:0]          da, db;
  logic signed [tod_pkg::ZW-1:0] atan_v;

  assign da     = b_r >>> cnt_r;
  assign db     = a_r >>> cnt_r;
  assign atan_v = tod_pkg::ZW'(tod_pkg::atan_q24(tod_pkg::ATAN_IDX_W'(cnt_r)));

  assign status.last_step = (cnt_r == CW'(CORDIC_STEPS - 1));

  // Round Q.24 to Q2.13 and clamp to +-pi.
  logic signed [tod_pkg::ZW-1:0] z_bias;
  logic signed [tod_pkg::RW-1:0] r_full;
  logic signed [tod_pkg::ANGLE_W-1:0] r_clamp;

  assign z_bias = z_r + tod_pkg::ZW'(tod_pkg::ROUND_BIAS);
  assign r_full = tod_pkg::RW'(z_bias >>> tod_pkg::ROUND_SH);

  always_comb begin
    if (zero_r) begin
      r_clamp = tod_pkg::ANGLE_W'(tod_pkg::PI_Q13);
    end else if (r_full > tod_pkg::RW'(tod_pkg::PI_Q13)) begin
      r_clamp = tod_pkg::ANGLE_W'(tod_pkg::PI_Q13);
    end else if (r_full < -tod_pkg::RW'(tod_pkg::PI_Q13)) begin
      r_clamp = -tod_pkg::ANGLE_W'(tod_pkg::PI_Q13);
    end else begin
      r_clamp = tod_pkg::ANGLE_W'(r_full);
    end
  end

  // Band classification, first match wins.
  logic signed [TW-1:0] ang_t, fe_t, pl_t, ph_t, le_t;
  logic [tod_pkg::CODE_W-1:0] band;

  assign ang_t = TW'(angle_r);
  assign fe_t  = $signed({2'b00, flat_edge_r});
  assign pl_t  = $signed({2'b00, portrait_low_r});
  assign ph_t  = $signed({2'b00, portrait_high_r});
  assign le_t  = $signed({2'b00, left_edge_r});

  always_comb begin
    if (ang_t >= -ph_t && ang_t <= -pl_t) begin
      band = tod_pkg::ORI_PORTRAIT;
    end else if (ang_t >= -fe_t && ang_t <= fe_t) begin
      band = tod_pkg::ORI_LAND_RIGHT;
    end else if (ang_t >= pl_t && ang_t <= ph_t) begin
      band = tod_pkg::ORI_UPSIDE;
    end else if (ang_t <= -le_t || ang_t >= le_t) begin
      band = tod_pkg::ORI_LAND_LEFT;
    end else begin
      band = tod_pkg::ORI_UNKNOWN;
    end
  end

  logic upd;
  assign upd = (band != tod_pkg::ORI_UNKNOWN) && (band != ori_r);

  // Control state: configuration and detected orientation.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flat_edge_r     <= tod_pkg::FLAT_EDGE_RST;
      portrait_low_r  <= tod_pkg::PORTRAIT_LOW_RST;
      portrait_high_r <= tod_pkg::PORTRAIT_HIGH_RST;
      left_edge_r     <= tod_pkg::LEFT_EDGE_RST;
      ori_r           <= tod_pkg::ORI_UNKNOWN;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          tod_pkg::REG_FLAT_EDGE:     flat_edge_r     <= cfg_data;
          tod_pkg::REG_PORTRAIT_LOW:  portrait_low_r  <= cfg_data;
          tod_pkg::REG_PORTRAIT_HIGH: portrait_high_r <= cfg_data;
          tod_pkg::REG_LEFT_EDGE:     left_edge_r     <= cfg_data;
          default: begin
          end
        endcase
      end
      if (cmd.emit && upd) begin
        ori_r <= band;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cnt_r  <= '0;
      zero_r <= (sx == '0) && (sy == '0);
      if (sx > 0) begin
        // first component negative: turn by pi
        a_r <= sx_w;
        b_r <= -sy_w;
        z_r <= (sy >= 0) ? tod_pkg::ZW'(tod_pkg::PI_Q24) : -tod_pkg::ZW'(tod_pkg::PI_Q24);
      end else begin
        a_r <= -sx_w;
        b_r <= sy_w;
        z_r <= '0;
      end
    end else if (cmd.iter) begin
      cnt_r <= cnt_r + CW'(1);
      if (b_r >= 0) begin
        a_r <= a_r + da;
        b_r <= b_r - db;
        z_r <= z_r + atan_v;
      end else begin
        a_r <= a_r - da;
        b_r <= b_r + db;
        z_r <= z_r - atan_v;
      end
    end
    if (cmd.round) begin
      angle_r <= r_clamp;
    end
    if (cmd.emit) begin
      out_angle_r   <= angle_r;
      out_code_r    <= upd ? band : ori_r;
      out_changed_r <= upd;
    end
  end

  assign out_angle   = out_angle_r;
  assign out_code    = out_code_r;
  assign out_changed = out_changed_r;

endmodule

/* rtl/core/tilt_orientation_detector_top.sv */
// Top level of the tilt orientation detector: controller plus datapath.
// Usage:
//   Input stream in_*: one item per sample, in_tdata = {accel_y, accel_x}
//   as 16-bit two's complement values (4096 per g).
//   Output stream out_*: one item per sample carrying the tilt angle
//   atan2(y, -x) in Q2.13 radians, the current orientation code and a
//   flag that is set when this sample changed the orientation.
//   Configuration port cfg_*: write band edges (Q2.13) while idle;
//   index 0 flat_edge, 1 portrait_low, 2 portrait_high, 3 left_edge.
// Flow:
//   An item runs through one shared CORDIC stage that iterates once per
//   cycle, then is rounded and emitted into the output register; a new
//   item is accepted only after the previous one has been emitted.
//   The output register decouples the sides: a finished result waits there
//   while the next sample is taken and iterated; a stalled receiver only
//   holds the block once a second result is ready.
// Reset: rst_n (synchronous, active low) empties the pipeline, sets the
//   orientation to unknown and loads the default band edges.
module tilt_orientation_detector_top #(
  parameter int SAMPLE_WIDTH = tod_pkg::SAMPLE_WIDTH_DEF,
  parameter int CORDIC_STEPS = tod_pkg::CORDIC_STEPS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // in_tdata: [15:0] accel_x, [31:16] accel_y
  input  logic [tod_pkg::IN_DATA_W-1:0]       in_tdata,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // out_tdata: [15:0] tilt_angle, [18:16] orientation_code,
  //            [19] orientation_changed, [23:20] zero
  output logic [tod_pkg::OUT_DATA_W-1:0]      out_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  input  logic                                cfg_we,
  input  logic [tod_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tod_pkg::CFG_W-1:0]           cfg_data
);

  tod_pkg::dp_cmd_t    cmd;
  tod_pkg::dp_status_t status;

  logic signed [tod_pkg::ANGLE_W-1:0] out_angle;
  logic [tod_pkg::CODE_W-1:0]         out_code;
  logic                               out_changed;

  // Sequence load, iterate, round and emit.
  tod_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  // Hold the CORDIC registers, band edges and the orientation.
  tod_dp #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .status      (status),
    .in_accel_x  (in_tdata[15:0]),
    .in_accel_y  (in_tdata[31:16]),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .out_angle   (out_angle),
    .out_code    (out_code),
    .out_changed (out_changed)
  );

  // Pack the result, pad to whole bytes.
  assign out_tdata = {4'b0000, out_changed, out_code, out_angle};

`ifndef SYNTHESIS
  // Busy right after taking an item.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("accepted a second item while the first was iterating");

  // A change always lands on a real orientation.
  a_changed_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[19] |-> out_tdata[18:16] != tod_pkg::ORI_UNKNOWN)
    else $error("orientation changed to unknown");

  // Angle stays within +-pi.
  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[15:0]) <= $signed(16'sd25736)) &&
                   ($signed(out_tdata[15:0]) >= $signed(-16'sd25736)))
    else $error("tilt angle outside +-pi");
`endif

endmodule
